### rtl/core/trivariate_polynomial_accumulator_assert.svh
// assertion macros for the trivariate polynomial accumulator checkers
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TRIVARIATE_POLYNOMIAL_ACCUMULATOR_ASSERT_SVH
`define TRIVARIATE_POLYNOMIAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define TPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpa port check failed");

// next-cycle implication
`define TPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpa port check failed");

`endif

### rtl/core/tpa_pkg.sv
// shared types, codes and fixed-point helpers of the polynomial accumulator
// no dependencies
`timescale 1ns / 1ps

package tpa_pkg;

  localparam int COEFF_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int THR_W      = 16;
  localparam int EXP_W      = 4;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = 2 * COEFF_W;
  localparam int IN_DATA_W  = 2 * COEFF_W + 6 * EXP_W;
  localparam int IN_USER_W  = KIND_W;
  localparam int OUT_DATA_W = COEFF_W;
  localparam int OUT_USER_W = STATUS_W;

  typedef logic [COEFF_W-1:0] coeff_t;

  localparam coeff_t LIM_POS = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam coeff_t LIM_NEG = {1'b1, {(COEFF_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SCALE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_EXP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEGREE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } mul_res_t;

  typedef struct packed {
    logic   sat;
    coeff_t val;
  } coeff_sat_t;

  function automatic coeff_t mag_of(input coeff_t v);
    return v[COEFF_W-1] ? (~v + COEFF_W'(1)) : v;
  endfunction

  function automatic logic is_small(input coeff_t v, input logic [THR_W-1:0] thr);
    return mag_of(v) <= COEFF_W'(thr);
  endfunction

  // round half away from zero, then saturate
  function automatic coeff_sat_t round_prod(input mul_res_t p);
    logic [PROD_W-1:0]           rnd;
    logic [PROD_W-FRAC_BITS-1:0] mag;
    coeff_sat_t                  r;
    rnd   = p.mag + RND_HALF;
    mag   = rnd[PROD_W-1:FRAC_BITS];
    r.sat = 1'b0;
    if (p.neg) begin
      if (mag > (PROD_W-FRAC_BITS)'(LIM_NEG)) begin
        r.sat = 1'b1;
        r.val = LIM_NEG;
      end else begin
        r.val = ~mag[COEFF_W-1:0] + COEFF_W'(1);
      end
    end else begin
      if (mag > (PROD_W-FRAC_BITS)'(LIM_POS)) begin
        r.sat = 1'b1;
        r.val = LIM_POS;
      end else begin
        r.val = mag[COEFF_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic coeff_sat_t sat_add(input coeff_t a, input coeff_t b);
    logic [COEFF_W:0] s;
    coeff_sat_t       r;
    s = {a[COEFF_W-1], a} + {b[COEFF_W-1], b};
    if (s[COEFF_W] != s[COEFF_W-1]) begin
      r.sat = 1'b1;
      r.val = s[COEFF_W] ? LIM_NEG : LIM_POS;
    end else begin
      r.sat = 1'b0;
      r.val = s[COEFF_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/tpa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tpa_mul.sv
// registered sign-magnitude multiplier for q16.16 coefficients
// depends on tpa_pkg
`timescale 1ns / 1ps

module tpa_mul
  import tpa_pkg::*;
(
  input  logic     clk_i,
  input  coeff_t   a_i,
  input  coeff_t   b_i,
  output mul_res_t res_o
);

  mul_res_t res_d, res_q;
  coeff_t   a_mag, b_mag;

  always_comb begin
    a_mag     = mag_of(a_i);
    b_mag     = mag_of(b_i);
    res_d.neg = a_i[COEFF_W-1] ^ b_i[COEFF_W-1];
    res_d.mag = PROD_W'(a_mag) * PROD_W'(b_mag);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

### rtl/core/trivariate_polynomial_accumulator.sv
// top level of the trivariate polynomial accumulator: control, walk pipeline, output register
// depends on tpa_pkg, tpa_ram and tpa_mul
//
//  channel   direction  fields
//  s_axis    in         tuser: kind; tdata: coeff_a, exp_ax/ay/az, coeff_b, exp_bx/by/bz
//  m_axis    out        tuser: status; tdata: coeff_out
//  cfg       in         data: zero_threshold
//
// add, multiply and read: multiplier, ram read, update, output (S_MUL, S_TERM, S_UPD, S_OUT); result loaded in S_OUT
// errors and unused kinds: go straight to S_OUT, where the result is loaded
// clear and scale: one sweep of the coefficient ram in S_WALK, then result loaded in S_OUT
// after reset the ram is cleared by the same sweep, tready rises when the sweep is done
// a result waiting on m_axis holds the next item back only after it has been processed
`timescale 1ns / 1ps

module trivariate_polynomial_accumulator
  import tpa_pkg::*;
#(
  parameter int MAX_EXP = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // coeff_a, exp_ax, exp_ay, exp_az, coeff_b, exp_bx, exp_by, exp_bz
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // coeff_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [THR_W-1:0]      cfg_data_i
);

  localparam int B     = MAX_EXP + 1;
  localparam int DEPTH = B * B * B;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [EXP_W:0] MAX_E = (EXP_W+1)'(MAX_EXP);

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_TERM = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_WALK = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  function automatic logic [AW-1:0] tab_idx(input logic [EXP_W:0] x, input logic [EXP_W:0] y,
                                            input logic [EXP_W:0] z);
    return AW'(int'(x) * B * B + int'(y) * B + int'(z));
  endfunction

  state_e state_d, state_q;
  logic [CW-1:0] rd_cnt_d, rd_cnt_q;
  logic v1_d, v1_q, v2_d, v2_q;
  logic sat_acc_d, sat_acc_q;
  logic out_valid_d, out_valid_q;
  logic [THR_W-1:0] thr_d, thr_q;

  logic [KIND_W-1:0] kind_d, kind_q;
  coeff_t ca_d, ca_q, cb_d, cb_q;
  logic [AW-1:0] addr_d, addr_q, idx1_d, idx1_q, idx2_d, idx2_q;
  logic wipe_d, wipe_q;
  coeff_t res_d, res_q, t_d, t_q;
  logic [STATUS_W-1:0] st_d, st_q;
  logic tsat_d, tsat_q, tsmall_d, tsmall_q;
  coeff_t out_data_d, out_data_q;
  logic [STATUS_W-1:0] out_user_d, out_user_q;

  // incoming fields
  logic [KIND_W-1:0] in_kind;
  coeff_t in_ca, in_cb;
  logic [EXP_W:0] ax, ay, az, bx, by, bz, sx, sy, sz;
  logic a_bad, b_bad, sum_bad, in_acc;

  // ram and multiplier
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  coeff_t ram_wdata, ram_rdata;
  coeff_t mul_a, mul_b;
  mul_res_t mul_res;
  coeff_sat_t prod_rs, sum_rs;
  coeff_t walk_val, upd_val;
  logic walking, walk_wipe, rd_more, walk_done, out_free;

  tpa_ram #(
    .WIDTH(COEFF_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tpa_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .res_o(mul_res)
  );

  assign in_kind = s_axis_tuser[KIND_W-1:0];
  assign in_ca   = s_axis_tdata[31:0];
  assign ax      = {1'b0, s_axis_tdata[35:32]};
  assign ay      = {1'b0, s_axis_tdata[39:36]};
  assign az      = {1'b0, s_axis_tdata[43:40]};
  assign in_cb   = s_axis_tdata[75:44];
  assign bx      = {1'b0, s_axis_tdata[79:76]};
  assign by      = {1'b0, s_axis_tdata[83:80]};
  assign bz      = {1'b0, s_axis_tdata[87:84]};
  assign sx      = ax + bx;
  assign sy      = ay + by;
  assign sz      = az + bz;
  assign a_bad   = (ax > MAX_E) || (ay > MAX_E) || (az > MAX_E);
  assign b_bad   = (bx > MAX_E) || (by > MAX_E) || (bz > MAX_E);
  assign sum_bad = (sx > MAX_E) || (sy > MAX_E) || (sz > MAX_E);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign walking   = (state_q == S_INIT) || (state_q == S_WALK);
  assign walk_wipe = (state_q == S_INIT) || wipe_q;
  assign rd_more   = rd_cnt_q < CW'(DEPTH);
  assign walk_done = !rd_more && !v1_q && !v2_q;

  assign mul_a   = (state_q == S_MUL) ? ca_q : ram_rdata;
  assign mul_b   = (state_q == S_MUL) ? cb_q : ca_q;
  assign prod_rs = round_prod(mul_res);
  assign sum_rs  = sat_add(ram_rdata, t_q);

  always_comb begin
    walk_val = prod_rs.val;
    if (walk_wipe || is_small(prod_rs.val, thr_q)) begin
      walk_val = '0;
    end
    upd_val = is_small(sum_rs.val, thr_q) ? '0 : sum_rs.val;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = upd_val;
    if (walking) begin
      ram_re    = rd_more;
      ram_raddr = rd_cnt_q[AW-1:0];
      ram_we    = v2_q;
      ram_waddr = idx2_q;
      ram_wdata = walk_val;
    end else if (state_q == S_TERM) begin
      ram_re = 1'b1;
    end else if (state_q == S_UPD) begin
      ram_we = (kind_q != KIND_READ) && !tsmall_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    sat_acc_d   = sat_acc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    thr_d       = cfg_valid_i ? cfg_data_i : thr_q;
    kind_d      = kind_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    addr_d      = addr_q;
    wipe_d      = wipe_q;
    res_d       = res_q;
    st_d        = st_q;
    t_d         = t_q;
    tsat_d      = tsat_q;
    tsmall_d    = tsmall_q;
    idx1_d      = rd_cnt_q[AW-1:0];
    idx2_d      = idx1_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    if (walking) begin
      v1_d = rd_more;
      v2_d = v1_q;
      if (rd_more) begin
        rd_cnt_d = rd_cnt_q + CW'(1);
      end
      if (v2_q && !walk_wipe && prod_rs.sat) begin
        sat_acc_d = 1'b1;
      end
    end

    case (state_q)
      S_INIT: begin
        if (walk_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_d = in_kind;
          ca_d   = in_ca;
          cb_d   = in_cb;
          res_d  = '0;
          st_d   = ST_OK;
          addr_d = tab_idx(ax, ay, az);
          case (in_kind)
            KIND_ADD, KIND_READ: begin
              if (a_bad) begin
                st_d    = ST_BAD_EXP;
                state_d = S_OUT;
              end else begin
                state_d = S_MUL;
              end
            end
            KIND_MUL: begin
              addr_d = tab_idx(sx, sy, sz);
              if (a_bad || b_bad) begin
                st_d    = ST_BAD_EXP;
                state_d = S_OUT;
              end else if (sum_bad) begin
                st_d    = ST_DEGREE;
                state_d = S_OUT;
              end else begin
                state_d = S_MUL;
              end
            end
            KIND_CLEAR, KIND_SCALE: begin
              wipe_d    = (in_kind == KIND_CLEAR) || is_small(in_ca, thr_q);
              rd_cnt_d  = '0;
              sat_acc_d = 1'b0;
              state_d   = S_WALK;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_MUL: begin
        state_d = S_TERM;
      end
      S_TERM: begin
        t_d      = (kind_q == KIND_MUL) ? prod_rs.val : ca_q;
        tsat_d   = (kind_q == KIND_MUL) && prod_rs.sat;
        tsmall_d = is_small(t_d, thr_q);
        state_d  = S_UPD;
      end
      S_UPD: begin
        res_d = ram_rdata;
        st_d  = ST_OK;
        if (kind_q != KIND_READ) begin
          if (tsmall_q) begin
            st_d = tsat_q ? ST_SAT : ST_OK;
          end else begin
            res_d = upd_val;
            st_d  = (tsat_q || sum_rs.sat) ? ST_SAT : ST_OK;
          end
        end
        state_d = S_OUT;
      end
      S_WALK: begin
        if (walk_done) begin
          res_d   = '0;
          st_d    = sat_acc_q ? ST_SAT : ST_OK;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          out_user_d  = st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      rd_cnt_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      sat_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= '0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      sat_acc_q   <= sat_acc_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    ca_q       <= ca_d;
    cb_q       <= cb_d;
    addr_q     <= addr_d;
    wipe_q     <= wipe_d;
    res_q      <= res_d;
    st_q       <= st_d;
    t_q        <= t_d;
    tsat_q     <= tsat_d;
    tsmall_q   <= tsmall_d;
    idx1_q     <= idx1_d;
    idx2_q     <= idx2_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

endmodule

### rtl/core/tpa_checker.sv
// port-level checks of the polynomial accumulator, bound to the top level
// depends on tpa_pkg and trivariate_polynomial_accumulator_assert.svh
`timescale 1ns / 1ps
`include "trivariate_polynomial_accumulator_assert.svh"

module tpa_checker
  import tpa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic s_acc, m_stall;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // one transaction at a time: busy right after acceptance
  `TPA_ASSERT_NXT(busy_after_accept, s_acc, !s_axis_tready)
  // no result can appear the cycle after acceptance
  `TPA_ASSERT_NXT(no_early_result, s_acc, !$rose(m_axis_tvalid))
  `TPA_ASSERT_NXT(out_valid_held, m_stall, m_axis_tvalid)
  `TPA_ASSERT_NXT(out_payload_held, m_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind trivariate_polynomial_accumulator tpa_checker u_tpa_checker (.*);
